/* rtl/core/pidpd_pkg.sv */
// ----------------------------------------------------------------------------
// pidpd_pkg
// Shared types and constants for the positional/incremental PID controller.
// ----------------------------------------------------------------------------
package pidpd_pkg;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_MODE   = 3'd0;
    localparam cfg_idx_t REG_GAIN_P = 3'd1;
    localparam cfg_idx_t REG_GAIN_I = 3'd2;
    localparam cfg_idx_t REG_GAIN_D = 3'd3;
    localparam cfg_idx_t REG_GAIN_F = 3'd4;
    localparam cfg_idx_t REG_LIMITS = 3'd5;
    localparam cfg_idx_t REG_BANDS  = 3'd6;

    localparam int CFG_W  = 64;
    localparam int GAIN_W = 32;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 21;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W  = 56;
    localparam int IVAL_W = 50;
    localparam int ISUM_W = 48;
    localparam int DIV_W  = 63;
    localparam int DVS_W  = 16;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/pidpd_if.sv */
// ----------------------------------------------------------------------------
// pidpd_in_if / pidpd_out_if
// Valid/ready channels carrying controller input items and result items.
// ----------------------------------------------------------------------------
interface pidpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured;
    logic signed [15:0] setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface pidpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

/* rtl/core/pidpd_mul.sv */
// ----------------------------------------------------------------------------
// pidpd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidpd_mul (
    input  logic                                clk,
    input  logic signed [pidpd_pkg::MUL_A_W-1:0] a,
    input  logic signed [pidpd_pkg::MUL_B_W-1:0] b,
    output logic signed [pidpd_pkg::PROD_W-1:0]  prod
);
    import pidpd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;
endmodule

/* rtl/core/pidpd_div.sv */
// ----------------------------------------------------------------------------
// pidpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidpd_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pidpd_pkg::DIV_W-1:0]      dividend,
    input  logic [pidpd_pkg::DVS_W-1:0]      divisor,
    output logic [pidpd_pkg::DIV_W-1:0]      quot,
    output pidpd_pkg::div_stat_t             stat
);
    import pidpd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quot      = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

/* rtl/core/pid_position_delta_controller.sv */
// ----------------------------------------------------------------------------
// pid_position_delta_controller
// Positional / incremental PID over one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Path from the accepting edge to out valid: the check alone in the deadband;
//   DP, DD, DI, DIC, SUM in delta mode; MF, MP, MD, MI, ISEL, ICLAMP, SUM in
//   position mode, plus WL, WH, WC and the 63-step divider, which sets the long
//   case, when the integral takes the linear weighting band. One item at a time;
//   the next is taken once back in idle. The multiplier issues one product a cycle.
// Reset clears configuration, error history, integrator, held drives and out valid, not the drive register.
module pid_position_delta_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  pidpd_pkg::cfg_idx_t          cfg_index,
    input  logic [pidpd_pkg::CFG_W-1:0]  cfg_data,
    pidpd_in_if.sink                     in_ch,
    pidpd_out_if.source                  out_ch
);
    import pidpd_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_MF     = 5'd2;
    localparam logic [4:0] S_MP     = 5'd3;
    localparam logic [4:0] S_MD     = 5'd4;
    localparam logic [4:0] S_MI     = 5'd5;
    localparam logic [4:0] S_ISEL   = 5'd6;
    localparam logic [4:0] S_WL     = 5'd7;
    localparam logic [4:0] S_WH     = 5'd8;
    localparam logic [4:0] S_WC     = 5'd9;
    localparam logic [4:0] S_DIV    = 5'd10;
    localparam logic [4:0] S_ICLAMP = 5'd11;
    localparam logic [4:0] S_DP     = 5'd12;
    localparam logic [4:0] S_DD     = 5'd13;
    localparam logic [4:0] S_DI     = 5'd14;
    localparam logic [4:0] S_DIC    = 5'd15;
    localparam logic [4:0] S_SUM    = 5'd16;

    // Clip x to [-(lo_mag << 16), hi_mag << 16]
    function automatic logic signed [31:0] sat_q(input logic signed [ACC_W-1:0] x,
                                                 input logic [14:0] lo_mag,
                                                 input logic [14:0] hi_mag);
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] hi;
        logic signed [31:0]      r;
        lo = -$signed({{(ACC_W-31){1'b0}}, lo_mag, 16'b0});
        hi =  $signed({{(ACC_W-31){1'b0}}, hi_mag, 16'b0});
        if (x > hi)
            r = hi[31:0];
        else if (x < lo)
            r = lo[31:0];
        else
            r = x[31:0];
        return r;
    endfunction

    // Configuration
    logic                     mode_reg;
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_f_reg;
    logic [59:0]              limits_reg;
    logic [63:0]              bands_reg;

    // Control and state
    logic [4:0]               state_reg, state_next;
    logic signed [15:0]       set_reg, set_next;
    logic signed [16:0]       err_reg, err_next;
    logic signed [16:0]       ep_reg, ep_next;
    logic signed [16:0]       ep2_reg, ep2_next;
    logic signed [ISUM_W-1:0] isum_reg, isum_next;
    logic signed [15:0]       pos_held_reg, pos_held_next;
    logic signed [15:0]       dlt_held_reg, dlt_held_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [IVAL_W-1:0] ival_reg, ival_next;
    logic [46:0]              mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [15:0]              w_reg, w_next;
    logic [39:0]              lo_reg, lo_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [15:0]       drive_reg, drive_next;

    // Shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_W-1:0]          quot;
    div_stat_t                 div_st;

    // Derived values
    logic [14:0]        lim_out, lim_ff, lim_up, lim_dn;
    logic [15:0]        b_dead, b_min, b_mid, b_max;
    logic [16:0]        aerr;
    logic signed [17:0] diff1;
    logic signed [19:0] diff2;
    logic               sep_on;
    logic               dead_hit;
    logic               slot_free;
    logic signed [ISUM_W-1:0] isum_half;
    logic signed [IVAL_W-1:0] iinc;
    logic signed [IVAL_W-1:0] qs;
    logic signed [31:0] iclamp;
    logic signed [31:0] oclip;
    logic signed [31:0] oadj;

    assign lim_out = limits_reg[14:0];
    assign lim_ff  = limits_reg[29:15];
    assign lim_up  = limits_reg[44:30];
    assign lim_dn  = limits_reg[59:45];
    assign b_dead  = bands_reg[15:0];
    assign b_min   = bands_reg[31:16];
    assign b_mid   = bands_reg[47:32];
    assign b_max   = bands_reg[63:48];

    assign aerr      = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign diff1     = 18'(err_reg) - 18'(ep_reg);
    assign diff2     = 20'(err_reg) - (20'(ep_reg) <<< 1) + 20'(ep2_reg);
    assign sep_on    = (b_max > b_mid) && (b_mid > b_min);
    assign dead_hit  = aerr < {1'b0, b_dead};
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign isum_half = (isum_reg + $signed({{(ISUM_W-1){1'b0}}, isum_reg[ISUM_W-1]})) >>> 1;
    assign iinc      = $signed(prod[IVAL_W-1:0]);
    assign qs        = $signed({{(IVAL_W-47){1'b0}}, quot[46:0]});
    assign oclip     = sat_q(acc_reg, lim_out, lim_out);
    assign oadj      = oclip + (oclip[31] ? 32'sd65535 : 32'sd0);
    assign div_dividend = {prod[38:0], 24'b0} + {23'b0, lo_reg};

    pidpd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pidpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (b_max - b_mid),
        .quot     (quot),
        .stat     (div_st)
    );

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MF:
            begin
                mul_a = MUL_A_W'(gain_f_reg);
                mul_b = MUL_B_W'(set_reg);
            end
            S_MP, S_DP:
            begin
                mul_a = MUL_A_W'(gain_p_reg);
                mul_b = (state_reg == S_MP) ? MUL_B_W'(err_reg) : MUL_B_W'(diff1);
            end
            S_MD:
            begin
                mul_a = MUL_A_W'(gain_d_reg);
                mul_b = MUL_B_W'(diff1);
            end
            S_DD:
            begin
                mul_a = MUL_A_W'(gain_d_reg);
                mul_b = MUL_B_W'(diff2);
            end
            S_MI, S_DI:
            begin
                mul_a = MUL_A_W'(gain_i_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            S_WL:
            begin
                mul_a = $signed({9'b0, mag_reg[23:0]});
                mul_b = $signed({5'b0, w_reg});
            end
            S_WH:
            begin
                mul_a = $signed({10'b0, mag_reg[46:24]});
                mul_b = $signed({5'b0, w_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequence one item through the shared units
    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        err_next       = err_reg;
        ep_next        = ep_reg;
        ep2_next       = ep2_reg;
        isum_next      = isum_reg;
        pos_held_next  = pos_held_reg;
        dlt_held_next  = dlt_held_reg;
        acc_next       = acc_reg;
        ival_next      = ival_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        drive_next     = drive_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        div_start      = 1'b0;
        iclamp         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    set_next   = in_ch.setpoint;
                    err_next   = 17'(in_ch.setpoint) - 17'(in_ch.measured);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dead_hit)
                begin
                    if (slot_free)
                    begin
                        drive_next     = mode_reg ? dlt_held_reg : pos_held_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                    state_next = mode_reg ? S_DP : S_MF;
            end
            S_MF:
                state_next = S_MP;
            S_MP:
            begin
                acc_next   = ACC_W'(sat_q(ACC_W'(prod), lim_ff, lim_ff));
                state_next = S_MD;
            end
            S_MD:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = S_MI;
            end
            S_MI:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = S_ISEL;
            end
            S_ISEL:
            begin
                state_next = S_ICLAMP;
                if (sep_on && aerr > {1'b0, b_max})
                    ival_next = IVAL_W'(isum_half);
                else if (sep_on && aerr > {1'b0, b_mid})
                begin
                    neg_next   = iinc[IVAL_W-1];
                    mag_next   = iinc[IVAL_W-1] ? 47'(-iinc) : 47'(iinc);
                    w_next     = b_max - aerr[15:0];
                    state_next = S_WL;
                end
                else if (!sep_on || aerr > {1'b0, b_min})
                    ival_next = IVAL_W'(isum_reg) + iinc;
                else
                    ival_next = IVAL_W'(isum_reg);
            end
            S_WL:
                state_next = S_WH;
            S_WH:
            begin
                lo_next    = prod[39:0];
                state_next = S_WC;
            end
            S_WC:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    ival_next  = neg_reg ? IVAL_W'(isum_reg) - qs : IVAL_W'(isum_reg) + qs;
                    state_next = S_ICLAMP;
                end
            end
            S_ICLAMP:
            begin
                if (lim_up != '0 && lim_dn != '0)
                    iclamp = sat_q(ACC_W'(ival_reg), lim_dn, lim_up);
                isum_next  = ISUM_W'(iclamp);
                acc_next   = acc_reg + ACC_W'(iclamp);
                state_next = S_SUM;
            end
            S_DP:
                state_next = S_DD;
            S_DD:
            begin
                acc_next   = $signed({{(ACC_W-32){dlt_held_reg[15]}}, dlt_held_reg, 16'b0})
                             + ACC_W'(prod);
                state_next = S_DI;
            end
            S_DI:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = S_DIC;
            end
            S_DIC:
            begin
                if (lim_up != '0 || lim_dn != '0)
                    iclamp = sat_q(ACC_W'(prod), lim_dn, lim_up);
                acc_next   = acc_reg + ACC_W'(iclamp);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (slot_free)
                begin
                    drive_next     = oadj[31:16];
                    out_valid_next = 1'b1;
                    if (mode_reg)
                        dlt_held_next = oadj[31:16];
                    else
                        pos_held_next = oadj[31:16];
                    ep2_next   = ep_reg;
                    ep_next    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ep_reg        <= '0;
            ep2_reg       <= '0;
            isum_reg      <= '0;
            pos_held_reg  <= '0;
            dlt_held_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ep_reg        <= ep_next;
            ep2_reg       <= ep2_next;
            isum_reg      <= isum_next;
            pos_held_reg  <= pos_held_next;
            dlt_held_reg  <= dlt_held_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        set_reg   <= set_next;
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        ival_reg  <= ival_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        w_reg     <= w_next;
        lo_reg    <= lo_next;
        drive_reg <= drive_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            gain_f_reg <= '0;
            limits_reg <= '0;
            bands_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_GAIN_P: gain_p_reg <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I: gain_i_reg <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D: gain_d_reg <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_F: gain_f_reg <= $signed(cfg_data[GAIN_W-1:0]);
                REG_LIMITS: limits_reg <= cfg_data[59:0];
                REG_BANDS:  bands_reg  <= cfg_data;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.drive = drive_reg;

    // An accepted item always goes to the deadband check
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == S_CHECK))
        else $error("accepted item did not reach deadband check");

    // A deadband hit leaves the integrator untouched
    a_dead_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && dead_hit) |=> $stable(isum_reg))
        else $error("integrator changed inside deadband");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // Divider is started only when idle
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    // Drive never reaches the most negative code
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg != 16'sh8000))
        else $error("drive out of range");
endmodule

/* tb/pid_position_delta_controller_tb.sv */
// ----------------------------------------------------------------------------
// pid_position_delta_controller_tb
// Self-checking bench for the positional/incremental PID controller. A directed
// table walks the extremes, the deadband, the three integral separation bands,
// anti-windup and both modes. Random phases with random register settings then
// follow. Every drive item is checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module pid_position_delta_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidpd_pkg::*;

    localparam longint QONE = 65536;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic signed [15:0] drive;
        bit                 typed;
        logic signed [15:0] typed_drive;
    } drive_exp_t;

    typedef struct {
        bit                 is_reg;
        cfg_idx_t           idx;
        logic [CFG_W-1:0]   data;
        logic signed [15:0] meas;
        logic signed [15:0] setp;
        bit                 typed;
        logic signed [15:0] typed_drive;
    } step_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pidpd_in_if  in_ch ();
    pidpd_out_if out_ch ();

    pid_position_delta_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Controller copy: configuration and state
    bit     m_mode;
    longint m_gp, m_gi, m_gd, m_gf;
    logic [59:0] m_limits;
    logic [63:0] m_bands;
    longint m_eprev, m_eprev2, m_isum, m_pos_held, m_delta_held;

    drive_exp_t drive_q[$];
    step_t      steps[$];
    int         n_errors;
    int         n_items;
    int         n_checked;
    bit         rx_idle_on;
    bit         tx_idle_on;
    bit         hold_req;
    int         hold_left;
    bit                 cur_typed;
    logic signed [15:0] cur_typed_drive;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Advance the controller copy by one item and return its drive
    function automatic logic signed [15:0] pid_drive(input logic signed [15:0] meas,
                                                     input logic signed [15:0] setp);
        longint err, aerr, out_lim, ff_lim, up_lim, dn_lim;
        longint dead, bmin, bmid, bmax;
        longint fout, pout, iinc, iout, dout, sum, res;
        longint unsigned mag, quo;
        err     = longint'(setp) - longint'(meas);
        aerr    = err < 0 ? -err : err;
        out_lim = longint'(m_limits[14:0]) * QONE;
        ff_lim  = longint'(m_limits[29:15]) * QONE;
        up_lim  = longint'(m_limits[44:30]) * QONE;
        dn_lim  = longint'(m_limits[59:45]) * QONE;
        dead    = longint'(m_bands[15:0]);
        bmin    = longint'(m_bands[31:16]);
        bmid    = longint'(m_bands[47:32]);
        bmax    = longint'(m_bands[63:48]);
        // Hold the last drive of the active mode inside the deadband
        if (aerr < dead)
            return m_mode ? m_delta_held[15:0] : m_pos_held[15:0];
        if (!m_mode)
        begin
            fout = clip(m_gf * longint'(setp), -ff_lim, ff_lim);
            pout = m_gp * err;
            iinc = m_gi * err;
            iout = m_isum;
            if (bmax > bmid && bmid > bmin)
            begin
                if (aerr > bmax)
                    iout = iout / 2;
                else if (aerr > bmid)
                begin
                    mag = longint'(iinc < 0 ? -iinc : iinc);
                    quo = mag * longint'(bmax - aerr) / longint'(bmax - bmid);
                    iout += iinc < 0 ? -longint'(quo) : longint'(quo);
                end
                else if (aerr > bmin)
                    iout += iinc;
            end
            else
                iout += iinc;
            if (up_lim > 0 && dn_lim > 0)
                iout = clip(iout, -dn_lim, up_lim);
            else
                iout = 0;
            m_isum     = iout;
            dout       = m_gd * (err - m_eprev);
            sum        = clip(fout + pout + iout + dout, -out_lim, out_lim);
            m_pos_held = sum / QONE;
            res        = m_pos_held;
        end
        else
        begin
            pout = m_gp * (err - m_eprev);
            iout = m_gi * err;
            dout = m_gd * (err - 2 * m_eprev + m_eprev2);
            if (up_lim > -dn_lim)
                iout = clip(iout, -dn_lim, up_lim);
            else
                iout = 0;
            sum          = clip(m_delta_held * QONE + pout + iout + dout, -out_lim, out_lim);
            m_delta_held = sum / QONE;
            res          = m_delta_held;
        end
        m_eprev2 = m_eprev;
        m_eprev  = err;
        return res[15:0];
    endfunction

    // Predict on each accepted input item
    always @(posedge clk)
    begin
        drive_exp_t e;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            e.drive       = pid_drive(in_ch.measured, in_ch.setpoint);
            e.typed       = cur_typed;
            e.typed_drive = cur_typed_drive;
            drive_q.push_back(e);
        end
    end

    // Check each accepted drive item against the oldest expectation
    always @(posedge clk)
    begin
        drive_exp_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_checked++;
            if (drive_q.size() == 0)
                report($sformatf("unexpected drive %0d", out_ch.drive));
            else
            begin
                e = drive_q.pop_front();
                if (out_ch.drive !== e.drive)
                    report($sformatf("drive %0d, predicted %0d", out_ch.drive, e.drive));
                if (e.typed && out_ch.drive !== e.typed_drive)
                    report($sformatf("drive %0d, table says %0d", out_ch.drive,
                                     e.typed_drive));
            end
        end
    end

    // Receiver: random idling, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_left = 300;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= !rx_idle_on || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   m_mode   = data[0];
            REG_GAIN_P: m_gp     = longint'($signed(data[31:0]));
            REG_GAIN_I: m_gi     = longint'($signed(data[31:0]));
            REG_GAIN_D: m_gd     = longint'($signed(data[31:0]));
            REG_GAIN_F: m_gf     = longint'($signed(data[31:0]));
            REG_LIMITS: m_limits = data[59:0];
            REG_BANDS:  m_bands  = data;
            default: ;
        endcase
    endtask

    // Drain the block before touching its registers
    task automatic wait_idle();
        wait (drive_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic signed [15:0] meas, input logic signed [15:0] setp,
                             input bit typed, input logic signed [15:0] typed_drive);
        while (tx_idle_on && $urandom_range(0, 99) < 19)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cur_typed       <= typed;
        cur_typed_drive <= typed_drive;
        in_ch.valid     <= 1'b1;
        in_ch.measured  <= meas;
        in_ch.setpoint  <= setp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_items++;
    endtask

    function automatic void add_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        step_t s;
        s = '{is_reg: 1'b1, idx: idx, data: data, meas: '0, setp: '0,
              typed: 1'b0, typed_drive: '0};
        steps.push_back(s);
    endfunction

    function automatic void add_item(input int meas, input int setp,
                                     input bit typed, input int typed_drive);
        step_t s;
        s = '{is_reg: 1'b0, idx: REG_MODE, data: '0, meas: meas[15:0], setp: setp[15:0],
              typed: typed, typed_drive: typed_drive[15:0]};
        steps.push_back(s);
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'd0;
            default: return 32'($signed($urandom_range(0, 8 * QONE)) - 4 * QONE);
        endcase
    endfunction

    function automatic logic [14:0] rand_lim();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'h7FFF;
            default: return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    // Write every register with a fresh random setting
    task automatic random_setting();
        logic [15:0] dead, bmin, bmid, bmax;
        dead = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 40));
        bmin = 16'($urandom_range(0, 200));
        bmid = bmin + 16'($urandom_range(1, 2000));
        bmax = bmid + 16'($urandom_range(1, 20000));
        if ($urandom_range(0, 4) == 0)
            {bmax, bmid, bmin} = {16'($urandom()), 16'($urandom()), 16'($urandom())};
        write_reg(REG_MODE, CFG_W'($urandom_range(0, 1)));
        write_reg(REG_GAIN_P, CFG_W'(rand_gain()));
        write_reg(REG_GAIN_I, CFG_W'(rand_gain()));
        write_reg(REG_GAIN_D, CFG_W'(rand_gain()));
        write_reg(REG_GAIN_F, CFG_W'(rand_gain()));
        write_reg(REG_LIMITS, CFG_W'({rand_lim(), rand_lim(), rand_lim(), rand_lim()}));
        write_reg(REG_BANDS, {bmax, bmid, bmin, dead});
    endtask

    task automatic random_items(input int count);
        int s, d, span;
        span = int'(m_bands[63:48]) + 2000;
        for (int i = 0; i < count; i++)
        begin
            s = int'($signed(16'($urandom())));
            // Mostly errors around the separation bands, sometimes full range
            if ($urandom_range(0, 9) < 7)
            begin
                d = $urandom_range(0, 2 * span) - span;
                d = s - d;
                d = d > 32767 ? 32767 : (d < -32768 ? -32768 : d);
            end
            else
                d = int'($signed(16'($urandom())));
            send_item(d[15:0], s[15:0], 1'b0, '0);
            if (i == count / 2 && $urandom_range(0, 3) == 0)
            begin
                in_ch.valid <= 1'b0;
                wait (drive_q.size() == 0);
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        step_t st;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_MODE;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.measured  = '0;
        in_ch.setpoint  = '0;
        rx_idle_on      = 1'b1;
        tx_idle_on      = 1'b1;
        hold_req        = 1'b0;
        cur_typed       = 1'b0;
        cur_typed_drive = '0;
        n_errors        = 0;
        n_items         = 0;
        n_checked       = 0;
        m_mode = 1'b0;
        m_gp = 0; m_gi = 0; m_gd = 0; m_gf = 0;
        m_limits = '0; m_bands = '0;
        m_eprev = 0; m_eprev2 = 0; m_isum = 0; m_pos_held = 0; m_delta_held = 0;

        // Directed table: reset state, extremes, bands, anti-windup, both modes
        add_item(-32768, 32767, 1, 0);
        add_item(32767, -32768, 1, 0);
        add_item(0, 0, 1, 0);
        add_reg(REG_LIMITS, {15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF});
        add_reg(REG_GAIN_P, 64'h1_0000);
        add_item(0, 100, 1, 100);
        add_item(-32768, 32767, 1, 32767);
        add_item(32767, -32768, 1, -32767);
        add_reg(REG_GAIN_I, 64'h8000);
        add_reg(REG_GAIN_D, 64'h4000);
        add_reg(REG_GAIN_F, 64'h1000);
        add_reg(REG_BANDS, {16'd1000, 16'd100, 16'd10, 16'd5});
        add_item(0, 3, 1, -32767);
        add_item(0, 20, 0, 0);
        add_item(0, 500, 0, 0);
        add_item(0, 5000, 0, 0);
        add_item(0, 50, 0, 0);
        add_reg(REG_LIMITS, {15'h0, 15'h7FFF, 15'h7FFF, 15'h7FFF});
        add_item(0, 200, 0, 0);
        add_reg(REG_MODE, 64'd1);
        add_item(0, 300, 0, 0);
        add_item(0, -300, 0, 0);
        add_item(0, 2, 0, 0);
        add_reg(REG_LIMITS, 64'd0);
        add_item(0, 1000, 1, 0);
        add_reg(REG_GAIN_P, 64'h7FFF_FFFF);
        add_reg(REG_GAIN_I, 64'h8000_0000);
        add_reg(REG_GAIN_D, 64'h8000_0000);
        add_reg(REG_GAIN_F, 64'h7FFF_FFFF);
        add_reg(REG_LIMITS, {15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF});
        add_reg(REG_BANDS, 64'd0);
        add_item(-32768, 32767, 0, 0);
        add_item(32767, -32768, 0, 0);
        add_reg(REG_MODE, 64'd0);
        add_item(-32768, 32767, 0, 0);
        add_item(32767, -32768, 0, 0);
        add_reg(REG_BANDS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(-32768, 32767, 0, 0);
        add_item(0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Walk the table
        foreach (steps[i])
        begin
            st = steps[i];
            if (st.is_reg)
            begin
                in_ch.valid <= 1'b0;
                wait_idle();
                write_reg(st.idx, st.data);
            end
            else
                send_item(st.meas, st.setp, st.typed, st.typed_drive);
        end
        in_ch.valid <= 1'b0;

        // Random phases, each under a new register setting
        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            random_setting();
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            if (ph == 4)
                hold_req = 1'b1;
            random_items(155);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        wait (drive_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d input items and %0d drive items over directed and 7 random",
                 n_items, n_checked);
        $display("register settings in position and delta mode, with stalls on both sides.");
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pidpd_pkg.sv
rtl/core/pidpd_if.sv
rtl/core/pidpd_mul.sv
rtl/core/pidpd_div.sv
rtl/core/pid_position_delta_controller.sv
tb/pid_position_delta_controller_tb.sv
